@@ hw/rtl/cpu6502_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpu6502_pkg
// Shared types, opcodes, micro-addresses and the control store for the
// LDA/JSR 6502 subset sequencer.
// ----------------------------------------------------------------------------
package cpu6502_pkg;

  localparam int unsigned MemBytes = 65536;
  localparam int unsigned MemAw    = $clog2(MemBytes);

  localparam logic [15:0] PcReset = 16'hFFFC;
  localparam logic [7:0]  SpReset = 8'hFF;
  localparam logic [7:0]  StackPage = 8'h01;

  localparam logic [7:0] OpJsr    = 8'h20;
  localparam logic [7:0] OpLdaImm = 8'hA9;
  localparam logic [7:0] OpLdaZp  = 8'hA5;
  localparam logic [7:0] OpLdaZpx = 8'hB5;
  localparam logic [7:0] OpLdaAbs = 8'hAD;
  localparam logic [7:0] OpLdaAbx = 8'hBD;
  localparam logic [7:0] OpLdaAby = 8'hB9;
  localparam logic [7:0] OpLdaInx = 8'hA1;
  localparam logic [7:0] OpLdaIny = 8'hB1;

  typedef enum logic [1:0] {
    F_WRITE = 2'd0,
    F_READ  = 2'd1,
    F_EXEC  = 2'd2,
    F_NOP   = 2'd3
  } func_e;

  typedef enum logic {
    CFG_INDEX_X = 1'b0,
    CFG_INDEX_Y = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    A_PC, A_ZP, A_ZP1, A_EA, A_STK, A_CMD
  } addr_sel_e;

  typedef enum logic [1:0] {
    W_CMD, W_RETHI, W_RETLO
  } wdata_sel_e;

  typedef enum logic [2:0] {
    L_NONE, L_T, L_LO, L_HI, L_ACC, L_RD, L_OP
  } ld_sel_e;

  typedef enum logic [1:0] {
    I_NONE, I_T_X, I_EA_X, I_EA_Y
  } idx_sel_e;

  typedef enum logic [2:0] {
    BR_NEXT, BR_JUMP, BR_FUNC, BR_OPC, BR_DONE
  } br_e;

  typedef logic [5:0] upc_t;

  typedef struct packed {
    br_e        br;
    upc_t       target;
    addr_sel_e  asel;
    logic       rd;
    logic       wr;
    wdata_sel_e wsel;
    logic       pinc;
    ld_sel_e    ld;
    idx_sel_e   idx;
    logic       spdec;
    logic       jmp;
  } ucode_t;

  typedef struct packed {
    logic       known;
    upc_t       entry;
    logic [2:0] cyc;
  } op_info_t;

  localparam upc_t U_IDLE  = 6'd0;
  localparam upc_t U_WR    = 6'd1;
  localparam upc_t U_RD    = 6'd2;
  localparam upc_t U_EX    = 6'd4;
  localparam upc_t U_JSR   = 6'd6;
  localparam upc_t U_IMM   = 6'd10;
  localparam upc_t U_LDACC = 6'd11;
  localparam upc_t U_ZP    = 6'd12;
  localparam upc_t U_ZPX   = 6'd14;
  localparam upc_t U_ZPRD  = 6'd17;
  localparam upc_t U_ABS   = 6'd18;
  localparam upc_t U_EARD  = 6'd21;
  localparam upc_t U_ABX   = 6'd22;
  localparam upc_t U_ABY   = 6'd26;
  localparam upc_t U_INX   = 6'd30;
  localparam upc_t U_PTR   = 6'd33;
  localparam upc_t U_INY   = 6'd36;
  localparam upc_t U_DONE  = 6'd42;
  localparam upc_t U_LAST  = U_DONE;

  function automatic op_info_t op_info(logic [7:0] op);
    op_info_t r;
    case (op)
      OpJsr:    r = '{1'b1, U_JSR, 3'd6};
      OpLdaImm: r = '{1'b1, U_IMM, 3'd2};
      OpLdaZp:  r = '{1'b1, U_ZP,  3'd3};
      OpLdaZpx: r = '{1'b1, U_ZPX, 3'd4};
      OpLdaAbs: r = '{1'b1, U_ABS, 3'd4};
      OpLdaAbx: r = '{1'b1, U_ABX, 3'd4};
      OpLdaAby: r = '{1'b1, U_ABY, 3'd4};
      OpLdaInx: r = '{1'b1, U_INX, 3'd6};
      OpLdaIny: r = '{1'b1, U_INY, 3'd5};
      default:  r = '{1'b0, U_DONE, 3'd0};
    endcase
    return r;
  endfunction

  // fields: br, target, asel, rd, wr, wsel, pinc, ld, idx, spdec, jmp
  function automatic ucode_t ucode_rom(upc_t a);
    ucode_t u;
    case (a)
      6'd0:  u = '{BR_FUNC, U_IDLE,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_NONE, I_NONE, 1'b0, 1'b0};
      6'd1:  u = '{BR_JUMP, U_DONE,  A_CMD, 1'b0, 1'b1, W_CMD,   1'b0, L_NONE, I_NONE, 1'b0, 1'b0};
      6'd2:  u = '{BR_NEXT, U_IDLE,  A_CMD, 1'b1, 1'b0, W_CMD,   1'b0, L_NONE, I_NONE, 1'b0, 1'b0};
      6'd3:  u = '{BR_JUMP, U_DONE,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_RD,   I_NONE, 1'b0, 1'b0};
      6'd4:  u = '{BR_NEXT, U_IDLE,  A_PC,  1'b1, 1'b0, W_CMD,   1'b1, L_NONE, I_NONE, 1'b0, 1'b0};
      6'd5:  u = '{BR_OPC,  U_IDLE,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_OP,   I_NONE, 1'b0, 1'b0};
      // JSR
      6'd6:  u = '{BR_NEXT, U_IDLE,  A_PC,  1'b1, 1'b0, W_CMD,   1'b1, L_NONE, I_NONE, 1'b0, 1'b0};
      6'd7:  u = '{BR_NEXT, U_IDLE,  A_PC,  1'b1, 1'b0, W_CMD,   1'b1, L_LO,   I_NONE, 1'b0, 1'b0};
      6'd8:  u = '{BR_NEXT, U_IDLE,  A_STK, 1'b0, 1'b1, W_RETHI, 1'b0, L_HI,   I_NONE, 1'b1, 1'b0};
      6'd9:  u = '{BR_JUMP, U_DONE,  A_STK, 1'b0, 1'b1, W_RETLO, 1'b0, L_NONE, I_NONE, 1'b1, 1'b1};
      // #imm, and the shared accumulator load
      6'd10: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b1, 1'b0, W_CMD,   1'b1, L_NONE, I_NONE, 1'b0, 1'b0};
      6'd11: u = '{BR_JUMP, U_DONE,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_ACC,  I_NONE, 1'b0, 1'b0};
      // zp
      6'd12: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b1, 1'b0, W_CMD,   1'b1, L_NONE, I_NONE, 1'b0, 1'b0};
      6'd13: u = '{BR_JUMP, U_ZPRD,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_T,    I_NONE, 1'b0, 1'b0};
      // zp,X
      6'd14: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b1, 1'b0, W_CMD,   1'b1, L_NONE, I_NONE, 1'b0, 1'b0};
      6'd15: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_T,    I_NONE, 1'b0, 1'b0};
      6'd16: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_NONE, I_T_X,  1'b0, 1'b0};
      6'd17: u = '{BR_JUMP, U_LDACC, A_ZP,  1'b1, 1'b0, W_CMD,   1'b0, L_NONE, I_NONE, 1'b0, 1'b0};
      // abs
      6'd18: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b1, 1'b0, W_CMD,   1'b1, L_NONE, I_NONE, 1'b0, 1'b0};
      6'd19: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b1, 1'b0, W_CMD,   1'b1, L_LO,   I_NONE, 1'b0, 1'b0};
      6'd20: u = '{BR_JUMP, U_EARD,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_HI,   I_NONE, 1'b0, 1'b0};
      6'd21: u = '{BR_JUMP, U_LDACC, A_EA,  1'b1, 1'b0, W_CMD,   1'b0, L_NONE, I_NONE, 1'b0, 1'b0};
      // abs,X
      6'd22: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b1, 1'b0, W_CMD,   1'b1, L_NONE, I_NONE, 1'b0, 1'b0};
      6'd23: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b1, 1'b0, W_CMD,   1'b1, L_LO,   I_NONE, 1'b0, 1'b0};
      6'd24: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_HI,   I_NONE, 1'b0, 1'b0};
      6'd25: u = '{BR_JUMP, U_EARD,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_NONE, I_EA_X, 1'b0, 1'b0};
      // abs,Y
      6'd26: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b1, 1'b0, W_CMD,   1'b1, L_NONE, I_NONE, 1'b0, 1'b0};
      6'd27: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b1, 1'b0, W_CMD,   1'b1, L_LO,   I_NONE, 1'b0, 1'b0};
      6'd28: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_HI,   I_NONE, 1'b0, 1'b0};
      6'd29: u = '{BR_JUMP, U_EARD,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_NONE, I_EA_Y, 1'b0, 1'b0};
      // (zp,X)
      6'd30: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b1, 1'b0, W_CMD,   1'b1, L_NONE, I_NONE, 1'b0, 1'b0};
      6'd31: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_T,    I_NONE, 1'b0, 1'b0};
      6'd32: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_NONE, I_T_X,  1'b0, 1'b0};
      6'd33: u = '{BR_NEXT, U_IDLE,  A_ZP,  1'b1, 1'b0, W_CMD,   1'b0, L_NONE, I_NONE, 1'b0, 1'b0};
      6'd34: u = '{BR_NEXT, U_IDLE,  A_ZP1, 1'b1, 1'b0, W_CMD,   1'b0, L_LO,   I_NONE, 1'b0, 1'b0};
      6'd35: u = '{BR_JUMP, U_EARD,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_HI,   I_NONE, 1'b0, 1'b0};
      // (zp),Y
      6'd36: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b1, 1'b0, W_CMD,   1'b1, L_NONE, I_NONE, 1'b0, 1'b0};
      6'd37: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_T,    I_NONE, 1'b0, 1'b0};
      6'd38: u = '{BR_NEXT, U_IDLE,  A_ZP,  1'b1, 1'b0, W_CMD,   1'b0, L_NONE, I_NONE, 1'b0, 1'b0};
      6'd39: u = '{BR_NEXT, U_IDLE,  A_ZP1, 1'b1, 1'b0, W_CMD,   1'b0, L_LO,   I_NONE, 1'b0, 1'b0};
      6'd40: u = '{BR_NEXT, U_IDLE,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_HI,   I_NONE, 1'b0, 1'b0};
      6'd41: u = '{BR_JUMP, U_EARD,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_NONE, I_EA_Y, 1'b0, 1'b0};
      6'd42: u = '{BR_DONE, U_IDLE,  A_PC,  1'b0, 1'b0, W_CMD,   1'b0, L_NONE, I_NONE, 1'b0, 1'b0};
      default: u = '{BR_JUMP, U_DONE, A_PC, 1'b0, 1'b0, W_CMD,   1'b0, L_NONE, I_NONE, 1'b0, 1'b0};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/cpu6502_lda_jsr_subset.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpu6502_lda_jsr_subset
// Microcoded 6502 subset (JSR and the eight LDA modes) over a 64 KiB
// on-chip memory, with memory write and read commands.
// ----------------------------------------------------------------------------
//  channel | signals                                        | dir
//  in      | in_valid_i/in_ready_o, func/mem_addr/mem_wdata | in
//  out     | out_valid_o/out_ready_i, eight result fields   | out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i (X, Y)        | in
//
// One word at a time; one microcode step per cycle.
// After reset a clearing pass writes zero to all 65536 bytes;
// in_ready_o stays low until it ends.
// A waiting result stalls the sequencer only at its final step.
// ----------------------------------------------------------------------------
module cpu6502_lda_jsr_subset
  import cpu6502_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [15:0] mem_addr_i,
  input  wire logic [7:0]  mem_wdata_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_data_o,
  output logic [7:0]       acc_o,
  output logic             zero_flag_o,
  output logic             neg_flag_o,
  output logic [15:0]      prog_counter_o,
  output logic [7:0]       stack_ptr_o,
  output logic [2:0]       cycles_used_o,
  output logic             fault_o
);

  upc_t        upc_q, upc_d;
  ucode_t      uc;
  logic        clr_busy_q, clr_busy_d;
  logic [MemAw-1:0] clr_addr_q, clr_addr_d;

  logic [15:0] pc_q, pc_d;
  logic [7:0]  sp_q, sp_d;
  logic [7:0]  acc_q, acc_d;
  logic        z_q, z_d, n_q, n_d;
  logic [7:0]  x_q, y_q;

  func_e       func_q, func_d;
  logic [15:0] cmd_addr_q, cmd_addr_d;
  logic [7:0]  cmd_wdata_q, cmd_wdata_d;
  logic [7:0]  op_q, op_d;
  logic [7:0]  t_q, t_d;
  logic [15:0] ea_q, ea_d;
  logic        cross_q, cross_d;
  logic [7:0]  rd_q, rd_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_rd_q, out_acc_q, out_sp_q;
  logic        out_z_q, out_n_q, out_fault_q;
  logic [15:0] out_pc_q;
  logic [2:0]  out_cyc_q;
  logic        out_load;

  logic [15:0] maddr;
  logic [15:0] ret_addr;
  logic [15:0] ea_sum;
  logic [7:0]  idx_val;
  logic [7:0]  mwdata;
  logic [7:0]  ram_rdata;
  logic        ram_we;
  logic [MemAw-1:0] ram_waddr;
  logic [7:0]  ram_wdata;
  logic        in_acc;
  op_info_t    info_now, info_q;

  assign uc         = ucode_rom(upc_q);
  assign in_ready_o = !clr_busy_q && (upc_q == U_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign info_now   = op_info(ram_rdata);
  assign info_q     = op_info(op_q);
  assign ret_addr   = pc_q - 16'd1;
  assign out_load   = (uc.br == BR_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    case (uc.asel)
      A_PC:    maddr = pc_q;
      A_ZP:    maddr = {8'h00, t_q};
      A_ZP1:   maddr = {8'h00, t_q + 8'd1};
      A_EA:    maddr = ea_q;
      A_STK:   maddr = {StackPage, sp_q};
      A_CMD:   maddr = cmd_addr_q;
      default: maddr = pc_q;
    endcase
    case (uc.wsel)
      W_CMD:   mwdata = cmd_wdata_q;
      W_RETHI: mwdata = ret_addr[15:8];
      W_RETLO: mwdata = ret_addr[7:0];
      default: mwdata = cmd_wdata_q;
    endcase
  end

  assign ram_we    = clr_busy_q || uc.wr;
  assign ram_waddr = clr_busy_q ? clr_addr_q : maddr;
  assign ram_wdata = clr_busy_q ? 8'h00 : mwdata;

  cpu6502_ram #(
    .Width(8),
    .Depth(MemBytes)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (uc.rd),
    .raddr_i(maddr),
    .rdata_o(ram_rdata)
  );

  // next micro-address
  always_comb begin
    upc_d = upc_q;
    case (uc.br)
      BR_NEXT: upc_d = upc_q + 6'd1;
      BR_JUMP: upc_d = uc.target;
      BR_FUNC: begin
        if (in_acc) begin
          case (func_e'(func_i))
            F_WRITE: upc_d = U_WR;
            F_READ:  upc_d = U_RD;
            F_EXEC:  upc_d = U_EX;
            default: upc_d = U_DONE;
          endcase
        end
      end
      BR_OPC:  upc_d = info_now.entry;
      BR_DONE: if (out_load) upc_d = U_IDLE;
      default: upc_d = U_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    clr_busy_d  = clr_busy_q;
    clr_addr_d  = clr_addr_q;
    pc_d        = pc_q;
    sp_d        = sp_q;
    acc_d       = acc_q;
    z_d         = z_q;
    n_d         = n_q;
    func_d      = func_q;
    cmd_addr_d  = cmd_addr_q;
    cmd_wdata_d = cmd_wdata_q;
    op_d        = op_q;
    t_d         = t_q;
    ea_d        = ea_q;
    cross_d     = cross_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q;
    idx_val     = (uc.idx == I_EA_Y) ? y_q : x_q;
    ea_sum      = ea_q + {8'h00, idx_val};

    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (&clr_addr_q) clr_busy_d = 1'b0;
    end

    if (in_acc) begin
      func_d      = func_e'(func_i);
      cmd_addr_d  = mem_addr_i;
      cmd_wdata_d = mem_wdata_i;
      rd_d        = 8'h00;
      cross_d     = 1'b0;
    end

    case (uc.ld)
      L_T:   t_d = ram_rdata;
      L_LO:  ea_d[7:0] = ram_rdata;
      L_HI:  ea_d[15:8] = ram_rdata;
      L_ACC: begin
        acc_d = ram_rdata;
        z_d   = (ram_rdata == 8'h00);
        n_d   = ram_rdata[7];
      end
      L_RD:  rd_d = ram_rdata;
      L_OP:  op_d = ram_rdata;
      default: ;
    endcase

    case (uc.idx)
      I_T_X: t_d = t_q + x_q;
      I_EA_X, I_EA_Y: begin
        ea_d    = ea_sum;
        cross_d = (ea_sum[15:8] != ea_q[15:8]);
      end
      default: ;
    endcase

    if (uc.pinc)  pc_d = pc_q + 16'd1;
    if (uc.jmp)   pc_d = ea_q;
    if (uc.spdec) sp_d = sp_q - 8'd1;

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= U_IDLE;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      pc_q        <= PcReset;
      sp_q        <= SpReset;
      acc_q       <= 8'h00;
      z_q         <= 1'b0;
      n_q         <= 1'b0;
      x_q         <= 8'h00;
      y_q         <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      clr_busy_q  <= clr_busy_d;
      clr_addr_q  <= clr_addr_d;
      pc_q        <= pc_d;
      sp_q        <= sp_d;
      acc_q       <= acc_d;
      z_q         <= z_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_INDEX_X: x_q <= cfg_wdata_i;
          CFG_INDEX_Y: y_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    cmd_addr_q  <= cmd_addr_d;
    cmd_wdata_q <= cmd_wdata_d;
    op_q        <= op_d;
    t_q         <= t_d;
    ea_q        <= ea_d;
    cross_q     <= cross_d;
    rd_q        <= rd_d;
    if (out_load) begin
      out_rd_q  <= rd_q;
      out_acc_q <= acc_q;
      out_z_q   <= z_q;
      out_n_q   <= n_q;
      out_pc_q  <= pc_q;
      out_sp_q  <= sp_q;
      if (func_q == F_EXEC) begin
        out_cyc_q   <= info_q.known ? info_q.cyc + {2'b00, cross_q} : 3'd0;
        out_fault_q <= !info_q.known;
      end else begin
        out_cyc_q   <= 3'd0;
        out_fault_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = out_rd_q;
  assign acc_o          = out_acc_q;
  assign zero_flag_o    = out_z_q;
  assign neg_flag_o     = out_n_q;
  assign prog_counter_o = out_pc_q;
  assign stack_ptr_o    = out_sp_q;
  assign cycles_used_o  = out_cyc_q;
  assign fault_o        = out_fault_q;

`ifndef SYNTHESIS
  a_no_accept_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !clr_busy_q)
    else $error("input accepted during clearing pass");

  a_upc_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q <= U_LAST)
    else $error("micro-address outside control store");

  a_fault_no_cycles : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fault_o) |-> (cycles_used_o == 3'd0))
    else $error("faulting word reports cycles");

  a_idle_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == U_IDLE && !clr_busy_q) |-> !ram_we)
    else $error("memory written while idle");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/cpu6502_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpu6502_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpu6502_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire
